@@ rtl/delta_list_timer_queue_macros.svh @@
// Assertion macros shared by the timer queue checkers.
// Each macro expands to one labeled concurrent assertion on clk_i, gated by rst_ni.
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// same-cycle implication
`define DLTQ_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("timer queue assertion failed");

// next-cycle implication
`define DLTQ_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("timer queue assertion failed");

`endif

@@ rtl/dltq_pkg.sv @@
// Shared types and constants for the delta-list timer queue.
// Used by the cell, the controller, the top level and the checker.
package dltq_pkg;

  localparam int DELTA_W      = 16;
  localparam int EVENT_W      = 8;
  localparam int RESULT_LIMIT = 16;
  localparam int NUM_W        = 5;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_TICK    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    LINK_INS_SEARCH,
    LINK_INS_CARRY,
    LINK_TICK_SUB
  } link_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRE,
    ST_RUN
  } state_e;

  // token handed from one cell to the next
  typedef struct packed {
    logic                 go;
    link_op_e             op;
    logic [DELTA_W-1:0]   val;
    logic [EVENT_W-1:0]   ev;
  } link_t;

  // contents of one cell
  typedef struct packed {
    logic                 valid;
    logic [DELTA_W-1:0]   delta;
    logic [EVENT_W-1:0]   ev;
  } entry_t;

endpackage

@@ rtl/delta_list_timer_queue.sv @@
// Delta-list timer queue: up to DEPTH pending events ordered by expiry, each cell holding
// its delay relative to the cell before it. An insert request keeps the queue busy while
// the insert token ripples one cell per cycle down the chain, and is rejected without a
// ripple when the queue is full. A tick request fires events from the head one by one,
// then sends the leftover tics down the chain with the same one-cell-per-cycle ripple
// when any remain on a non-empty queue. Fired events leave from the head, the chain
// shifting one place per event; a stalled result holds the firing and the next request
// until it is taken. At most 16 events fire per tick.
// Depends on dltq_pkg, dltq_ctrl and dltq_cell.
module delta_list_timer_queue #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  delay_i,
  input  logic [dltq_pkg::EVENT_W-1:0]  event_id_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  tick_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fired_o,
  output logic [dltq_pkg::EVENT_W-1:0]  fired_event_o,
  output logic                          insert_status_o,
  output logic                          last_o
);

  dltq_pkg::entry_t ent [DEPTH];
  dltq_pkg::link_t  lnk [DEPTH];
  logic             shift;

  dltq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .delay_i         (delay_i),
    .event_id_i      (event_id_i),
    .tick_count_i    (tick_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .fired_o         (fired_o),
    .fired_event_o   (fired_event_o),
    .insert_status_o (insert_status_o),
    .last_o          (last_o),
    .head_i          (ent[0]),
    .second_i        (ent[1]),
    .shift_o         (shift),
    .link_o          (lnk[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      dltq_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .link_i  (lnk[i]),
        .link_o  (lnk[i+1]),
        .next_i  (ent[i+1]),
        .entry_o (ent[i])
      );
    end else begin : g_tail
      dltq_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .link_i  (lnk[i]),
        .link_o  (),
        .next_i  ('0),
        .entry_o (ent[i])
      );
    end
  end

endmodule

@@ rtl/dltq_cell.sv @@
// One entry of the delta list: relative delay, event id and valid bit.
// Processes the token from its left neighbor and shifts from its right one.
// Depends on dltq_pkg.
module dltq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  dltq_pkg::link_t  link_i,
  output dltq_pkg::link_t  link_o,
  input  dltq_pkg::entry_t next_i,
  output dltq_pkg::entry_t entry_o
);

  logic                          valid_q, valid_d;
  logic [dltq_pkg::DELTA_W-1:0]  delta_q, delta_d;
  logic [dltq_pkg::EVENT_W-1:0]  ev_q, ev_d;
  dltq_pkg::link_t               link_q, link_d;

  always_comb begin
    valid_d   = valid_q;
    delta_d   = delta_q;
    ev_d      = ev_q;
    link_d    = link_i;
    link_d.go = 1'b0;
    if (shift_i) begin
      valid_d = next_i.valid;
      delta_d = next_i.delta;
      ev_d    = next_i.ev;
    end else if (link_i.go) begin
      case (link_i.op)
        dltq_pkg::LINK_INS_SEARCH: begin
          if (!valid_q) begin
            valid_d = 1'b1;
            delta_d = link_i.val;
            ev_d    = link_i.ev;
          end else if (delta_q <= link_i.val) begin
            link_d.go  = 1'b1;
            link_d.val = link_i.val - delta_q;
          end else begin
            delta_d    = link_i.val;
            ev_d       = link_i.ev;
            link_d.go  = 1'b1;
            link_d.op  = dltq_pkg::LINK_INS_CARRY;
            link_d.val = delta_q - link_i.val;
            link_d.ev  = ev_q;
          end
        end
        dltq_pkg::LINK_INS_CARRY: begin
          valid_d = 1'b1;
          delta_d = link_i.val;
          ev_d    = link_i.ev;
          if (valid_q) begin
            link_d.go  = 1'b1;
            link_d.val = delta_q;
            link_d.ev  = ev_q;
          end
        end
        dltq_pkg::LINK_TICK_SUB: begin
          if (valid_q) begin
            if (delta_q <= link_i.val) begin
              delta_d    = '0;
              link_d.go  = 1'b1;
              link_d.val = link_i.val - delta_q;
            end else begin
              delta_d = delta_q - link_i.val;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      link_q  <= '0;
    end else begin
      valid_q <= valid_d;
      link_q  <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    ev_q    <= ev_d;
  end

  assign link_o        = link_q;
  assign entry_o.valid = valid_q;
  assign entry_o.delta = delta_q;
  assign entry_o.ev    = ev_q;

endmodule

@@ rtl/dltq_ctrl.sv @@
// Request handling, head firing and result register of the timer queue.
// Drives the token into the cell chain and the shift toward the head.
// Depends on dltq_pkg.
module dltq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  delay_i,
  input  logic [dltq_pkg::EVENT_W-1:0]  event_id_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  tick_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fired_o,
  output logic [dltq_pkg::EVENT_W-1:0]  fired_event_o,
  output logic                          insert_status_o,
  output logic                          last_o,
  input  dltq_pkg::entry_t              head_i,
  input  dltq_pkg::entry_t              second_i,
  output logic                          shift_o,
  output dltq_pkg::link_t               link_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  dltq_pkg::state_e              state_q, state_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [dltq_pkg::DELTA_W-1:0]  rem_q, rem_d;
  logic [dltq_pkg::NUM_W-1:0]    n_q, n_d;
  dltq_pkg::link_t               link_q, link_d;
  logic                          out_valid_q, out_valid_d;
  logic                          fired_q, fired_d;
  logic [dltq_pkg::EVENT_W-1:0]  fev_q, fev_d;
  logic                          status_q, status_d;
  logic                          last_q, last_d;

  logic                          out_free, accept, full, fire_now, more, wrap_up;
  logic [dltq_pkg::DELTA_W-1:0]  rem_after;
  logic [dltq_pkg::NUM_W-1:0]    n_next;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == dltq_pkg::ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign rem_after  = rem_q - head_i.delta;
  assign n_next     = n_q + dltq_pkg::NUM_W'(1);
  assign fire_now   = (count_q != '0) && (head_i.delta <= rem_q)
                      && (n_q < dltq_pkg::NUM_W'(dltq_pkg::RESULT_LIMIT));
  assign more       = (count_q > CNT_W'(1)) && (second_i.delta <= rem_after)
                      && (n_next < dltq_pkg::NUM_W'(dltq_pkg::RESULT_LIMIT));
  assign wrap_up    = !fire_now && ((n_q != '0) || out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (accept) begin
          if (command_i == dltq_pkg::CMD_TICK) begin
            state_d = dltq_pkg::ST_FIRE;
          end else if (!full) begin
            state_d = dltq_pkg::ST_RUN;
          end
        end
      end
      dltq_pkg::ST_FIRE: begin
        if (wrap_up) begin
          if ((rem_q != '0) && (count_q != '0)) begin
            state_d = dltq_pkg::ST_RUN;
          end else begin
            state_d = dltq_pkg::ST_IDLE;
          end
        end
      end
      dltq_pkg::ST_RUN: begin
        if (cnt_q == '0) begin
          state_d = dltq_pkg::ST_IDLE;
        end
      end
      default: state_d = dltq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    n_d         = n_q;
    link_d      = link_q;
    link_d.go   = 1'b0;
    shift_o     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    fired_d     = fired_q;
    fev_d       = fev_q;
    status_d    = status_q;
    last_d      = last_q;
    case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (accept) begin
          if (command_i == dltq_pkg::CMD_TICK) begin
            rem_d = tick_count_i;
            n_d   = '0;
          end else begin
            out_valid_d = 1'b1;
            fired_d     = 1'b0;
            fev_d       = '0;
            status_d    = full ? dltq_pkg::STATUS_FULL : dltq_pkg::STATUS_OK;
            last_d      = 1'b1;
            if (!full) begin
              link_d.go  = 1'b1;
              link_d.op  = dltq_pkg::LINK_INS_SEARCH;
              link_d.val = delay_i;
              link_d.ev  = event_id_i;
              count_d    = count_q + CNT_W'(1);
              cnt_d      = CNT_W'(DEPTH);
            end
          end
        end
      end
      dltq_pkg::ST_FIRE: begin
        if (fire_now) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            fired_d     = 1'b1;
            fev_d       = head_i.ev;
            status_d    = dltq_pkg::STATUS_OK;
            last_d      = !more;
            shift_o     = 1'b1;
            count_d     = count_q - CNT_W'(1);
            rem_d       = rem_after;
            n_d         = n_next;
          end
        end else if (wrap_up) begin
          if (n_q == '0) begin
            out_valid_d = 1'b1;
            fired_d     = 1'b0;
            fev_d       = '0;
            status_d    = dltq_pkg::STATUS_OK;
            last_d      = 1'b1;
          end
          if ((rem_q != '0) && (count_q != '0)) begin
            link_d.go  = 1'b1;
            link_d.op  = dltq_pkg::LINK_TICK_SUB;
            link_d.val = rem_q;
            link_d.ev  = '0;
            cnt_d      = CNT_W'(DEPTH);
          end
        end
      end
      dltq_pkg::ST_RUN: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dltq_pkg::ST_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      link_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      link_q      <= link_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    fired_q  <= fired_d;
    fev_q    <= fev_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign link_o          = link_q;
  assign out_valid_o     = out_valid_q;
  assign fired_o         = fired_q;
  assign fired_event_o   = fev_q;
  assign insert_status_o = status_q;
  assign last_o          = last_q;

endmodule

@@ rtl/dltq_chk.sv @@
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and delta_list_timer_queue_macros.svh.
`include "delta_list_timer_queue_macros.svh"

module dltq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          command_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          fired_o,
  input logic [dltq_pkg::EVENT_W-1:0]  fired_event_o,
  input logic                          insert_status_o,
  input logic                          last_o
);

  logic [dltq_pkg::EVENT_W+2:0] result_bits;

  assign result_bits = {fired_o, fired_event_o, insert_status_o, last_o};

  `DLTQ_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_bits))

  `DLTQ_ASSERT_IMP(a_fired_ok, out_valid_o && fired_o, insert_status_o == dltq_pkg::STATUS_OK)

  `DLTQ_ASSERT_IMP(a_plain_last, out_valid_o && !fired_o, last_o)

  `DLTQ_ASSERT_NXT(a_tick_busy, in_valid_i && !in_stall_o && (command_i == dltq_pkg::CMD_TICK), in_stall_o)

endmodule

bind delta_list_timer_queue dltq_chk u_chk (.*);
